// ===== rtl/core/vrp_pkg.sv =====
// vertex_rotate_project package: shared types, constants and the cordic angle table
// no dependencies
package vrp_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned OutW      = 12;
  localparam int unsigned AngleW    = 32;
  localparam int unsigned TableLen  = 24;
  localparam int signed   OutMax    = 2047;
  localparam int signed   OutMin    = -2048;
  localparam longint      GainQ30   = 64'd652032874;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_X   = 3'd0,
    REG_STEP_Y   = 3'd1,
    REG_STEP_Z   = 3'd2,
    REG_VIEW_DST = 3'd3,
    REG_FOCAL    = 3'd4,
    REG_CENTRE_X = 3'd5,
    REG_CENTRE_Y = 3'd6
  } reg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIG,
    ST_MUL,
    ST_DIV_SETUP,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } seq_state_t;

  // request to the shared cordic
  typedef struct packed {
    logic              start;
    logic [AngleW-1:0] angle;
  } cordic_req_t;

  function automatic logic [AngleW-1:0] atan_turn(input logic [4:0] i);
    logic [AngleW-1:0] v;
    begin
      case (i)
        5'd0:  v = 32'h20000000;
        5'd1:  v = 32'h12E4051E;
        5'd2:  v = 32'h09FB385B;
        5'd3:  v = 32'h051111D4;
        5'd4:  v = 32'h028B0D43;
        5'd5:  v = 32'h0145D7E1;
        5'd6:  v = 32'h00A2F61E;
        5'd7:  v = 32'h00517C55;
        5'd8:  v = 32'h0028BE53;
        5'd9:  v = 32'h00145F2F;
        5'd10: v = 32'h000A2F98;
        5'd11: v = 32'h000517CC;
        5'd12: v = 32'h00028BE6;
        5'd13: v = 32'h000145F3;
        5'd14: v = 32'h0000A2FA;
        5'd15: v = 32'h0000517D;
        5'd16: v = 32'h000028BE;
        5'd17: v = 32'h0000145F;
        5'd18: v = 32'h00000A30;
        5'd19: v = 32'h00000518;
        5'd20: v = 32'h0000028C;
        5'd21: v = 32'h00000146;
        5'd22: v = 32'h000000A3;
        5'd23: v = 32'h00000051;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== rtl/core/vrp_stream_if.sv =====
// valid/ready channel interface carrying a packed payload
// depends on nothing
interface vrp_stream_if #(
  parameter int unsigned W = 19
) (
  input logic clk
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/vrp_cordic.sv =====
// iterative cordic: one micro-rotation per cycle, returns cos and sin
// depends on vrp_pkg
module vrp_cordic
  import vrp_pkg::*;
#(
  parameter int unsigned PHASE_BITS     = 16,
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cordic_req_t                     req,
  output logic                            done,
  output logic signed [TRIG_FRAC_BITS+3:0] cos_o,
  output logic signed [TRIG_FRAC_BITS+3:0] sin_o
);
  localparam int unsigned TW    = TRIG_FRAC_BITS + 4;
  localparam int unsigned NIter = (TRIG_FRAC_BITS + 2 < TableLen) ?
                                  TRIG_FRAC_BITS + 2 : TableLen;
  localparam longint      XInit = (GainQ30 + (64'sd1 <<< (29 - TRIG_FRAC_BITS)))
                                  >>> (30 - TRIG_FRAC_BITS);

  logic signed [TW-1:0]     x_r, y_r, x_nxt, y_nxt;
  logic signed [AngleW:0]   z_r, z_nxt;
  logic [4:0]               i_r, i_nxt;
  logic                     busy_r, busy_nxt, flip_r, flip_nxt;
  logic [AngleW-1:0]        u;
  logic signed [TW-1:0]     xs, ys;
  logic signed [AngleW:0]   at;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = $signed({1'b0, atan_turn(i_r)});

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    busy_nxt = busy_r; flip_nxt = flip_r;
    u = req.angle;
    if (req.start) begin
      flip_nxt = (u[AngleW-1:AngleW-2] == 2'b01) || (u[AngleW-1:AngleW-2] == 2'b10);
      if (flip_nxt) u[AngleW-1] = ~u[AngleW-1];
      z_nxt    = $signed({u[AngleW-1], u});
      x_nxt    = TW'(XInit);
      y_nxt    = '0;
      i_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[AngleW]) begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + at;
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(NIter - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      i_r    <= i_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
  end

  assign done  = busy_r && (i_r == 5'(NIter - 1)) ? 1'b0 : 1'b0 | (!busy_r && i_r == 5'(NIter));
  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;

`ifndef SYNTHESIS
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (i_r < 5'(NIter))) else $error("cordic iteration overrun");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !busy_r) else $error("done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("start did not launch");
`endif
endmodule

// ===== rtl/core/vrp_divider.sv =====
// restoring serial divider, one quotient bit per cycle, unsigned operands
// depends on vrp_pkg
module vrp_divider
  import vrp_pkg::*;
#(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt, trial;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt = num; rem_nxt = '0; cnt_nxt = CW'(NW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) d_r <= den;
  end

  assign busy = busy_r;
  assign quo  = q_r;
endmodule

// ===== rtl/core/vertex_rotate_project_core.sv =====
// vertex_rotate_project_core: rotates a vertex about x, y, z and projects it to screen
// depends on vrp_pkg, vrp_stream_if, vrp_cordic, vrp_divider
//
// usage:
//   in  channel payload {frame_start, vertex_x, vertex_y, vertex_z}, msb first
//   out channel payload {screen_x, screen_y, clipped}, msb first
//   cfg port: cfg_we, cfg_idx (0..6 step x/y/z, view distance, focal, centre x/y),
//   cfg_data; writes are registered, indexes beyond six are dropped
// operation: one transaction at a time; a frame_start transaction first advances
//   the three phase accumulators, then three cordic runs (one micro-rotation per
//   cycle), each followed by four products on one shared multiplier, then two
//   serial divides (one quotient bit per cycle)
// a new vertex is taken only once the last result has gone; in_ready is low while
//   a vertex is at work
// reset: phases clear, configuration registers take their defaults, no result pending
// a stalled receiver holds the result in the output register; the next vertex
//   is taken once out_valid has cleared and the sequencer is back in idle
module vertex_rotate_project_core
  import vrp_pkg::*;
#(
  parameter int unsigned PHASE_BITS     = 16,
  parameter int unsigned TRIG_FRAC_BITS = 14,
  parameter int unsigned COORD_BITS     = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  vrp_stream_if.sink          in_ch,
  vrp_stream_if.source        out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data
);
  localparam int unsigned TW   = TRIG_FRAC_BITS + 4;           // trig width
  localparam int unsigned VW   = COORD_BITS + TRIG_FRAC_BITS + 4; // coordinate width
  localparam int unsigned PW   = VW + TW;                      // product width
  localparam int unsigned NumW = VW + 8;                       // numerator magnitude
  localparam int unsigned InW  = 1 + 3 * COORD_BITS;

  // configuration
  logic [PHASE_BITS-1:0] step_x_r, step_y_r, step_z_r;
  logic [7:0]            view_r, focal_r, cx_r, cy_r;
  logic [PHASE_BITS-1:0] ph_x_r, ph_y_r, ph_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r <= PHASE_BITS'(522);
      step_y_r <= PHASE_BITS'(834);
      step_z_r <= PHASE_BITS'(313);
      view_r   <= 8'd60;
      focal_r  <= 8'd100;
      cx_r     <= 8'd64;
      cy_r     <= 8'd36;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_STEP_X:   step_x_r <= PHASE_BITS'(cfg_data);
        REG_STEP_Y:   step_y_r <= PHASE_BITS'(cfg_data);
        REG_STEP_Z:   step_z_r <= PHASE_BITS'(cfg_data);
        REG_VIEW_DST: view_r   <= cfg_data[7:0];
        REG_FOCAL:    focal_r  <= cfg_data[7:0];
        REG_CENTRE_X: cx_r     <= cfg_data[7:0];
        REG_CENTRE_Y: cy_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  seq_state_t            st_r, st_nxt;
  logic [1:0]            axis_r, axis_nxt;   // which rotation
  logic [1:0]            mstep_r, mstep_nxt; // product index within rotation
  logic                  dsel_r, dsel_nxt;   // 0: x divide, 1: y divide
  logic signed [VW-1:0]  vx_r, vy_r, vz_r;
  logic signed [PW-1:0]  p_r [4];
  logic signed [TW-1:0]  c_r, s_r;
  logic signed [OutW-1:0] sx_r, sy_r;
  logic                  clip_r;
  logic                  out_valid_r;

  // shared cordic
  cordic_req_t           creq;
  logic                  cdone;
  logic signed [TW-1:0]  ccos, csin;
  logic [PHASE_BITS-1:0] cur_phase;

  vrp_cordic #(.PHASE_BITS(PHASE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cordic (
    .clk, .rst_n, .req(creq), .done(cdone), .cos_o(ccos), .sin_o(csin)
  );

  // shared multiplier: coordinate times trig
  logic signed [VW-1:0] ma;
  logic signed [TW-1:0] mb;
  logic signed [PW-1:0] mprod;
  always_comb begin
    // rotation about x uses (y,z), about y (x,z), about z (x,y)
    logic signed [VW-1:0] a0, b0;
    case (axis_r)
      2'd0:    begin a0 = vy_r; b0 = vz_r; end
      2'd1:    begin a0 = vx_r; b0 = vz_r; end
      default: begin a0 = vx_r; b0 = vy_r; end
    endcase
    case (mstep_r)
      2'd0:    begin ma = a0; mb = c_r; end
      2'd1:    begin ma = b0; mb = s_r; end
      2'd2:    begin ma = a0; mb = s_r; end
      default: begin ma = b0; mb = c_r; end
    endcase
  end
  assign mprod = PW'(ma) * PW'(mb);

  // combining the four products of one rotation
  logic signed [PW-1:0] r0, r1;
  always_comb begin
    case (axis_r)
      2'd1:    begin r0 = p_r[0] + p_r[1]; r1 = p_r[3] - p_r[2]; end
      default: begin r0 = p_r[0] - p_r[1]; r1 = p_r[2] + p_r[3]; end
    endcase
  end

  // projection: numerator and denominator
  logic signed [VW+9:0]  num_s;
  logic signed [VW+1:0]  den_s;
  logic [NumW-1:0]       num_mag;
  logic                  den_bad;
  logic                  dstart, dbusy;
  logic [NumW-1:0]       dquo;
  logic signed [NumW+1:0] q_s, r_s;
  logic signed [OutW-1:0] res;
  logic                  res_clip;
  logic signed [OutW-1:0] cent;

  assign num_s   = (dsel_r ? (VW+10)'(vy_r) : (VW+10)'(vx_r)) * $signed({2'b00, focal_r});
  assign den_s   = (VW+2)'(vz_r) + $signed({2'b00, view_r, {TRIG_FRAC_BITS{1'b0}}});
  assign num_mag = num_s[VW+9] ? NumW'(-num_s) : NumW'(num_s);
  assign den_bad = (den_s <= 0);
  assign cent    = dsel_r ? $signed({4'b0, cy_r}) : $signed({4'b0, cx_r});

  vrp_divider #(.NW(NumW), .DW(VW+1)) u_div (
    .clk, .rst_n, .start(dstart), .num(num_mag), .den(den_s[VW:0]),
    .busy(dbusy), .quo(dquo)
  );

  always_comb begin
    q_s = $signed({2'b00, dquo});
    if (num_s[VW+9]) q_s = -q_s;
    r_s = q_s + (NumW+2)'(cent);
    res_clip = 1'b0;
    if (den_bad) begin
      res_clip = 1'b1;
      if (num_s > 0)      res = OutW'(OutMax);
      else if (num_s < 0) res = OutW'(OutMin);
      else                res = cent;
    end else if (r_s > OutMax) begin
      res = OutW'(OutMax); res_clip = 1'b1;
    end else if (r_s < OutMin) begin
      res = OutW'(OutMin); res_clip = 1'b1;
    end else begin
      res = OutW'(r_s);
    end
  end

  wire in_fire  = in_ch.valid && in_ch.ready;
  wire out_fire = out_ch.valid && out_ch.ready;

  // next-state logic
  always_comb begin
    st_nxt = st_r; axis_nxt = axis_r; mstep_nxt = mstep_r; dsel_nxt = dsel_r;
    case (st_r)
      ST_IDLE: if (in_fire) begin st_nxt = ST_TRIG; axis_nxt = 2'd0; end
      ST_TRIG: if (cdone) begin st_nxt = ST_MUL; mstep_nxt = 2'd0; end
      ST_MUL: begin
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == 2'd3) st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (axis_r == 2'd2) begin
          st_nxt = ST_DIV_SETUP; dsel_nxt = 1'b0;
        end else begin
          st_nxt = ST_TRIG; axis_nxt = axis_r + 2'd1;
        end
      end
      ST_DIV_SETUP: st_nxt = ST_DIV;
      ST_DIV: if (!dbusy) begin
        if (dsel_r) st_nxt = ST_OUT;
        else begin st_nxt = ST_DIV_SETUP; dsel_nxt = 1'b1; end
      end
      ST_OUT: if (!out_valid_r) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // output logic
  always_comb begin
    creq.start  = 1'b0;
    creq.angle  = {cur_phase, {(AngleW-PHASE_BITS){1'b0}}};
    dstart      = 1'b0;
    in_ch.ready = (st_r == ST_IDLE);
    case (st_r)
      ST_IDLE:      creq.start = in_fire;
      ST_FIN:       creq.start = (axis_r != 2'd2);
      ST_DIV_SETUP: dstart = 1'b1;
      default: ;
    endcase
  end

  // cordic start on entry uses phases already advanced: phases update at accept
  logic [PHASE_BITS-1:0] ph_x_nxt, ph_y_nxt, ph_z_nxt;
  always_comb begin
    ph_x_nxt = ph_x_r; ph_y_nxt = ph_y_r; ph_z_nxt = ph_z_r;
    if (in_fire && in_ch.data[InW-1]) begin
      ph_x_nxt = ph_x_r + step_x_r;
      ph_y_nxt = ph_y_r + step_y_r;
      ph_z_nxt = ph_z_r + step_z_r;
    end
  end

  // launch angle: in IDLE the x phase as it advances, in FIN the next axis
  always_comb begin
    if (st_r == ST_IDLE) begin
      cur_phase = ph_x_nxt;
    end else begin
      case (axis_r)
        2'd0:    cur_phase = ph_y_r;
        default: cur_phase = ph_z_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      axis_r      <= '0;
      mstep_r     <= '0;
      dsel_r      <= 1'b0;
      ph_x_r      <= '0;
      ph_y_r      <= '0;
      ph_z_r      <= '0;
      out_valid_r <= 1'b0;
      clip_r      <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      axis_r  <= axis_nxt;
      mstep_r <= mstep_nxt;
      dsel_r  <= dsel_nxt;
      ph_x_r  <= ph_x_nxt;
      ph_y_r  <= ph_y_nxt;
      ph_z_r  <= ph_z_nxt;
      if (out_fire) out_valid_r <= 1'b0;
      if (in_fire) clip_r <= 1'b0;
      if (st_r == ST_DIV && !dbusy) begin
        if (res_clip) clip_r <= 1'b1;
        if (dsel_r) out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      vx_r <= VW'($signed(in_ch.data[3*COORD_BITS-1:2*COORD_BITS])) <<< TRIG_FRAC_BITS;
      vy_r <= VW'($signed(in_ch.data[2*COORD_BITS-1:COORD_BITS])) <<< TRIG_FRAC_BITS;
      vz_r <= VW'($signed(in_ch.data[COORD_BITS-1:0])) <<< TRIG_FRAC_BITS;
    end else if (st_r == ST_FIN) begin
      case (axis_r)
        2'd0: begin
          vy_r <= VW'(r0 >>> TRIG_FRAC_BITS); vz_r <= VW'(r1 >>> TRIG_FRAC_BITS);
        end
        2'd1: begin
          vx_r <= VW'(r0 >>> TRIG_FRAC_BITS); vz_r <= VW'(r1 >>> TRIG_FRAC_BITS);
        end
        default: begin
          vx_r <= VW'(r0 >>> TRIG_FRAC_BITS); vy_r <= VW'(r1 >>> TRIG_FRAC_BITS);
        end
      endcase
    end
    if (st_r == ST_TRIG && cdone) begin
      c_r <= ccos; s_r <= csin;
    end
    if (st_r == ST_MUL) p_r[mstep_r] <= mprod;
    if (st_r == ST_DIV && !dbusy) begin
      if (dsel_r) sy_r <= res;
      else        sx_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = {sx_r, sy_r, clip_r};

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !in_ch.ready) else $error("accepted while busy");
  a_out_in_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (st_r == ST_OUT)) else $error("result outside output state");
  a_div_after_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV_SETUP) |=> dbusy) else $error("divider did not start");
`endif
endmodule
